// ----- hdl/lti_pkg.sv -----
`timescale 1ns / 1ps

package lti_pkg;

    // Widths of the turtle and configuration values
    localparam int Q_W       = 32;
    localparam int GREY_W    = 17;
    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 2;
    localparam int SYM_W     = 8;
    localparam int KIND_W    = 2;

    // Saved-turtle stack
    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    // Multiplier datapath: 32-bit vector times 19-bit signed coefficient
    localparam int COEF_W = 19;
    localparam int PROD_W = Q_W + COEF_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int GPROD_W = 2 * GREY_W;

    localparam logic signed [Q_W-1:0] DIR_ONE  = 32'sd65536;
    localparam logic [GREY_W-1:0]     GREY_ONE = 17'd65536;

    // Symbols acted on
    localparam logic [SYM_W-1:0] SYM_FWD   = 8'h46;  // F
    localparam logic [SYM_W-1:0] SYM_PUSH  = 8'h5B;  // [
    localparam logic [SYM_W-1:0] SYM_POP   = 8'h5D;  // ]
    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;  // +
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;  // -

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DSCALE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CSCALE = 2'd3;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_FWD,
        OP_PUSH,
        OP_POP,
        OP_ROTP,
        OP_ROTM
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        EV_SEG   = 2'd0,
        EV_UNDER = 2'd1,
        EV_OVER  = 2'd2
    } t_evt_kind;

    typedef enum logic [1:0] {
        BS_ISSUE,
        BS_WB_PUSH,
        BS_WB_ROT,
        BS_WB_POP
    } t_bstate;

    typedef struct packed {
        t_op  op;
        logic start;
    } t_cmd;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_W-1:0]      data;
    } t_cfg_wr;

    typedef struct packed {
        logic signed [Q_W-1:0] pos_x;
        logic signed [Q_W-1:0] pos_y;
        logic signed [Q_W-1:0] dir_x;
        logic signed [Q_W-1:0] dir_y;
        logic [GREY_W-1:0]     grey;
    } t_turtle;

    typedef struct packed {
        t_evt_kind             kind;
        logic signed [Q_W-1:0] start_x;
        logic signed [Q_W-1:0] start_y;
        logic signed [Q_W-1:0] end_x;
        logic signed [Q_W-1:0] end_y;
        logic [GREY_W-1:0]     grey;
    } t_evt;

    localparam t_turtle INIT_TURTLE = '{
        pos_x: '0, pos_y: '0, dir_x: '0, dir_y: DIR_ONE, grey: GREY_ONE
    };

    // Saturating signed add
    function automatic logic signed [Q_W-1:0] sat_add(
        input logic signed [Q_W-1:0] a,
        input logic signed [Q_W-1:0] b
    );
        logic signed [Q_W:0] s;
        s = {a[Q_W-1], a} + {b[Q_W-1], b};
        if (s[Q_W] != s[Q_W-1]) begin
            sat_add = s[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
        end else begin
            sat_add = s[Q_W-1:0];
        end
    endfunction

    // Round a Q.32 sum to Q.16 (ties up), then saturate to 32 bits
    function automatic logic signed [Q_W-1:0] rnd_sat(
        input logic signed [ACC_W-1:0] p
    );
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] q;
        t = p + ACC_W'(32768);
        q = t >>> 16;
        if ((&q[ACC_W-1:Q_W-1]) || !(|q[ACC_W-1:Q_W-1])) begin
            rnd_sat = q[Q_W-1:0];
        end else begin
            rnd_sat = q[ACC_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
        end
    endfunction

    // Round the grey product and clamp it to one
    function automatic logic [GREY_W-1:0] grey_rnd(
        input logic [GPROD_W-1:0] p
    );
        logic [GPROD_W:0]   t;
        logic [GPROD_W-16:0] q;
        t = {1'b0, p} + (GPROD_W+1)'(32768);
        q = t[GPROD_W:16];
        if (q > (GPROD_W-15)'(GREY_ONE)) begin
            grey_rnd = GREY_ONE;
        end else begin
            grey_rnd = q[GREY_W-1:0];
        end
    endfunction

endpackage

// ----- hdl/lti_ifs.sv -----
`timescale 1ns / 1ps

interface lti_sym_if import lti_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             start_new;

    modport source(output valid, output symbol, output start_new, input ready);
    modport sink(input valid, input symbol, input start_new, output ready);
endinterface

interface lti_evt_if import lti_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     event_kind;
    logic signed [Q_W-1:0] seg_start_x;
    logic signed [Q_W-1:0] seg_start_y;
    logic signed [Q_W-1:0] seg_end_x;
    logic signed [Q_W-1:0] seg_end_y;
    logic [GREY_W-1:0]     seg_grey;

    modport source(output valid, output event_kind, output seg_start_x, output seg_start_y,
                   output seg_end_x, output seg_end_y, output seg_grey, input ready);
    modport sink(input valid, input event_kind, input seg_start_x, input seg_start_y,
                 input seg_end_x, input seg_end_y, input seg_grey, output ready);
endinterface

// ----- hdl/lti_front.sv -----
`timescale 1ns / 1ps

module lti_front import lti_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lti_sym_if.sink       i_sym,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output t_cmd          o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    logic n_valid;
    t_cmd n_cmd;
    t_op  dec_op;

    // Decode the symbol into an operation
    always_comb begin
        unique case (i_sym.symbol)
            SYM_FWD:   dec_op = OP_FWD;
            SYM_PUSH:  dec_op = OP_PUSH;
            SYM_POP:   dec_op = OP_POP;
            SYM_PLUS:  dec_op = OP_ROTP;
            SYM_MINUS: dec_op = OP_ROTM;
            default:   dec_op = OP_NOP;
        endcase
    end

    assign i_sym.ready = !r_valid || i_cmd_ready;

    // Hold the decoded item; drop ignored symbols that do not restart the turtle
    always_comb begin
        n_valid = r_valid && !i_cmd_ready;
        n_cmd   = r_cmd;
        if (i_sym.valid && i_sym.ready) begin
            n_valid   = (dec_op != OP_NOP) || i_sym.start_new;
            n_cmd.op    = dec_op;
            n_cmd.start = i_sym.start_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

// ----- hdl/lti_queue.sv -----
`timescale 1ns / 1ps

module lti_queue import lti_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_cmd i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_out
);

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    t_cmd              r_q [QDEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              push;
    logic              pop;

    assign o_in_ready  = (r_cnt != QCNT_W'(QDEPTH));
    assign o_out_valid = (r_cnt != '0);
    assign o_out       = r_q[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_out_valid && i_out_ready;

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= i_in;
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("queue fill count beyond depth");
    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + QCNT_W'(1)))
        else $error("queue count missed a push");
    a_cnt_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_cnt == $past(r_cnt) - QCNT_W'(1)))
        else $error("queue count missed a pop");
`endif

endmodule

// ----- hdl/lti_back.sv -----
`timescale 1ns / 1ps

module lti_back import lti_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg_wr  i_cfg,
    input  logic     i_cmd_valid,
    output logic     o_cmd_ready,
    input  t_cmd     i_cmd,
    lti_evt_if.source o_evt
);

    // Configuration
    logic signed [CFG_W-1:0] r_cos;
    logic signed [CFG_W-1:0] r_sin;
    logic [GREY_W-1:0]       r_dscale;
    logic [GREY_W-1:0]       r_cscale;

    // Turtle state
    t_bstate          r_state, n_state;
    t_turtle          r_tur, n_tur;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Result register
    logic r_out_valid, n_out_valid;
    t_evt r_out, n_out;

    // Stack memory and multiplier stage
    t_turtle                  r_mem [STACK_DEPTH];
    t_turtle                  r_rd;
    logic signed [PROD_W-1:0] r_pa, r_pb, r_pc, r_pd;
    logic [GPROD_W-1:0]       r_pg;

    t_turtle                  eff;
    logic [CNT_W-1:0]         eff_cnt;
    logic [CNT_W-1:0]         cnt_m1;
    logic                     ovf, unf, emits, out_free, can_go, issue;
    logic                     mem_we, rd_en, mul_en;
    logic signed [COEF_W-1:0] s_pos, s_sel, cos_ext, dsc_ext, ka, kb;
    logic signed [PROD_W-1:0] ext_dx, ext_dy, ext_ka, ext_kb, ext_kc, ext_kd;
    logic signed [ACC_W-1:0]  acc_a, acc_b, acc_c, acc_d, acc_x, acc_y;
    logic signed [Q_W-1:0]    end_x, end_y, wb_x, wb_y;
    logic [GREY_W-1:0]        wb_grey;

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos    <= CFG_W'(65536);
            r_sin    <= '0;
            r_dscale <= GREY_ONE;
            r_cscale <= GREY_ONE;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                CFG_COS:    r_cos    <= i_cfg.data;
                CFG_SIN:    r_sin    <= i_cfg.data;
                CFG_DSCALE: r_dscale <= i_cfg.data[GREY_W-1:0];
                CFG_CSCALE: r_cscale <= i_cfg.data[GREY_W-1:0];
                default: ;
            endcase
        end
    end

    // Turtle seen by the item at issue: restart flag applies first
    always_comb begin
        if (i_cmd.start) begin
            eff     = INIT_TURTLE;
            eff_cnt = '0;
        end else begin
            eff     = r_tur;
            eff_cnt = r_cnt;
        end
        cnt_m1 = eff_cnt - CNT_W'(1);
        ovf    = (eff_cnt == CNT_W'(STACK_DEPTH));
        unf    = (eff_cnt == '0);
    end

    // Multiplier operands: rotation coefficients or push scale
    always_comb begin
        s_pos   = {r_sin[CFG_W-1], r_sin};
        s_sel   = (i_cmd.op == OP_ROTM) ? -s_pos : s_pos;
        cos_ext = {r_cos[CFG_W-1], r_cos};
        dsc_ext = {{(COEF_W-GREY_W){1'b0}}, r_dscale};
        ka      = (i_cmd.op == OP_PUSH) ? dsc_ext : cos_ext;
        kb      = s_sel;
        ext_dx  = PROD_W'(eff.dir_x);
        ext_dy  = PROD_W'(eff.dir_y);
        ext_ka  = PROD_W'(ka);
        ext_kb  = PROD_W'(kb);
        ext_kc  = PROD_W'(kb);
        ext_kd  = PROD_W'(ka);
    end

    // Write-back arithmetic on the registered products
    always_comb begin
        acc_a   = ACC_W'(r_pa);
        acc_b   = ACC_W'(r_pb);
        acc_c   = ACC_W'(r_pc);
        acc_d   = ACC_W'(r_pd);
        acc_x   = (r_state == BS_WB_ROT) ? (acc_a - acc_b) : acc_a;
        acc_y   = (r_state == BS_WB_ROT) ? (acc_c + acc_d) : acc_d;
        wb_x    = rnd_sat(acc_x);
        wb_y    = rnd_sat(acc_y);
        wb_grey = grey_rnd(r_pg);
        end_x   = sat_add(eff.pos_x, eff.dir_x);
        end_y   = sat_add(eff.pos_y, eff.dir_y);
    end

    // Issue and write-back control
    always_comb begin
        emits       = (i_cmd.op == OP_FWD) || ((i_cmd.op == OP_PUSH) && ovf)
                      || ((i_cmd.op == OP_POP) && unf);
        out_free    = !r_out_valid || o_evt.ready;
        can_go      = (r_state == BS_ISSUE) && (!emits || out_free);
        issue       = can_go && i_cmd_valid;
        o_cmd_ready = can_go;

        n_state     = r_state;
        n_tur       = r_tur;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_evt.ready;
        n_out       = r_out;
        mem_we      = 1'b0;
        rd_en       = 1'b0;
        mul_en      = 1'b0;

        unique case (r_state)
            BS_ISSUE: begin
                if (issue) begin
                    n_tur = eff;
                    n_cnt = eff_cnt;
                    unique case (i_cmd.op)
                        OP_FWD: begin
                            n_tur.pos_x   = end_x;
                            n_tur.pos_y   = end_y;
                            n_out_valid   = 1'b1;
                            n_out.kind    = EV_SEG;
                            n_out.start_x = eff.pos_x;
                            n_out.start_y = eff.pos_y;
                            n_out.end_x   = end_x;
                            n_out.end_y   = end_y;
                            n_out.grey    = eff.grey;
                        end
                        OP_PUSH: begin
                            if (ovf) begin
                                n_out_valid = 1'b1;
                                n_out       = '0;
                                n_out.kind  = EV_OVER;
                            end else begin
                                mem_we  = 1'b1;
                                mul_en  = 1'b1;
                                n_cnt   = eff_cnt + CNT_W'(1);
                                n_state = BS_WB_PUSH;
                            end
                        end
                        OP_POP: begin
                            if (unf) begin
                                n_out_valid = 1'b1;
                                n_out       = '0;
                                n_out.kind  = EV_UNDER;
                            end else begin
                                rd_en   = 1'b1;
                                n_cnt   = cnt_m1;
                                n_state = BS_WB_POP;
                            end
                        end
                        OP_ROTP, OP_ROTM: begin
                            mul_en  = 1'b1;
                            n_state = BS_WB_ROT;
                        end
                        default: ;
                    endcase
                end
            end
            BS_WB_PUSH: begin
                n_tur.dir_x = wb_x;
                n_tur.dir_y = wb_y;
                n_tur.grey  = wb_grey;
                n_state     = BS_ISSUE;
            end
            BS_WB_ROT: begin
                n_tur.dir_x = wb_x;
                n_tur.dir_y = wb_y;
                n_state     = BS_ISSUE;
            end
            BS_WB_POP: begin
                n_tur   = r_rd;
                n_state = BS_ISSUE;
            end
            default: n_state = BS_ISSUE;
        endcase
    end

    // State and turtle registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_ISSUE;
            r_tur       <= INIT_TURTLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tur       <= n_tur;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload, stack memory and products
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (mem_we) begin
            r_mem[eff_cnt[ADDR_W-1:0]] <= eff;
        end
        if (rd_en) begin
            r_rd <= r_mem[cnt_m1[ADDR_W-1:0]];
        end
        if (mul_en) begin
            r_pa <= ext_dx * ext_ka;
            r_pb <= ext_dy * ext_kb;
            r_pc <= ext_dx * ext_kc;
            r_pd <= ext_dy * ext_kd;
            r_pg <= {{GREY_W{1'b0}}, eff.grey} * {{GREY_W{1'b0}}, r_cscale};
        end
    end

    assign o_evt.valid       = r_out_valid;
    assign o_evt.event_kind  = r_out.kind;
    assign o_evt.seg_start_x = r_out.start_x;
    assign o_evt.seg_start_y = r_out.start_y;
    assign o_evt.seg_end_x   = r_out.end_x;
    assign o_evt.seg_end_y   = r_out.end_y;
    assign o_evt.seg_grey    = r_out.grey;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");
    a_wb_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != BS_ISSUE) |=> (r_state == BS_ISSUE))
        else $error("write-back lasted more than one cycle");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind != EV_SEG)) |->
            (r_out.start_x == '0 && r_out.start_y == '0 && r_out.end_x == '0
             && r_out.end_y == '0 && r_out.grey == '0))
        else $error("error item carries nonzero fields");
`endif

endmodule

// ----- hdl/lsystem_turtle_interpreter_top.sv -----
`timescale 1ns / 1ps

// 2-D L-system turtle interpreter. One ASCII symbol per input item; 'F' returns a
// segment item, '[' and ']' save and restore the turtle on a 64-entry stack (an
// error item is returned on overflow or underflow), '+' and '-' rotate the
// direction by the configured cosine and sine, all other symbols are dropped.
// The front decodes one item per cycle into a two-entry queue while it has room.
// The back takes 'F', stack errors and restarts in its issue state; '[', ']', '+'
// and '-' add a write-back state: the issue drives the multipliers or the stack
// memory read, whose registered outputs are written back to the turtle in the
// cycle after. Ignored symbols without start_new never reach the back. Results
// sit in an output register, so while one waits the back keeps taking resultless
// items. The stack memory has no reset; its entries are read only once written.
module lsystem_turtle_interpreter_top import lti_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    lti_sym_if.sink              i_sym,
    lti_evt_if.source            o_evt
);

    logic    fq_valid, fq_ready;
    t_cmd    fq_cmd;
    logic    qb_valid, qb_ready;
    t_cmd    qb_cmd;
    t_cfg_wr cfg_wr;

    // Bundle the configuration write
    assign cfg_wr.we   = i_cfg_we;
    assign cfg_wr.idx  = i_cfg_idx;
    assign cfg_wr.data = i_cfg_data;

    lti_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sym       (i_sym),
        .o_cmd_valid (fq_valid),
        .i_cmd_ready (fq_ready),
        .o_cmd       (fq_cmd)
    );

    lti_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (fq_valid),
        .o_in_ready  (fq_ready),
        .i_in        (fq_cmd),
        .o_out_valid (qb_valid),
        .i_out_ready (qb_ready),
        .o_out       (qb_cmd)
    );

    lti_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg_wr),
        .i_cmd_valid (qb_valid),
        .o_cmd_ready (qb_ready),
        .i_cmd       (qb_cmd),
        .o_evt       (o_evt)
    );

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import lti_pkg::*;

    // Predicts turtle results and checks the items that leave the block
    class turtle_scoreboard;
        t_turtle                 cur;
        t_turtle                 saved[STACK_DEPTH];
        int unsigned             depth;
        logic signed [CFG_W-1:0] cos_q;
        logic signed [CFG_W-1:0] sin_q;
        logic [GREY_W-1:0]       dir_gain;
        logic [GREY_W-1:0]       grey_gain;
        t_evt                    due_events[$];
        int unsigned             errors;
        int unsigned             segments;
        int unsigned             underflows;
        int unsigned             overflows;

        function new();
            cur       = INIT_TURTLE;
            depth     = 0;
            cos_q     = 18'sd65536;
            sin_q     = '0;
            dir_gain  = GREY_ONE;
            grey_gain = GREY_ONE;
            errors    = 0;
        endfunction

        // Round a Q.32 value to Q.16, ties upward
        function longint round_q16(longint p);
            return (p + 64'sd32768) >>> 16;
        endfunction

        function logic signed [Q_W-1:0] clamp_q(longint v);
            if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[Q_W-1:0];
        endfunction

        function void turn(longint s);
            longint c;
            longint nx;
            longint ny;
            c  = longint'(cos_q);
            nx = c * longint'($signed(cur.dir_x)) - s * longint'($signed(cur.dir_y));
            ny = s * longint'($signed(cur.dir_x)) + c * longint'($signed(cur.dir_y));
            cur.dir_x = clamp_q(round_q16(nx));
            cur.dir_y = clamp_q(round_q16(ny));
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_COS:    cos_q = data;
                CFG_SIN:    sin_q = data;
                CFG_DSCALE: dir_gain = data[GREY_W-1:0];
                CFG_CSCALE: grey_gain = data[GREY_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the turtle for one accepted symbol and queue its result, if any
        function void note_symbol(logic [SYM_W-1:0] sym, logic restart);
            t_evt   ev;
            longint g;
            ev = '{kind: EV_SEG, default: '0};
            if (restart) begin
                cur   = INIT_TURTLE;
                depth = 0;
            end
            case (sym)
                SYM_FWD: begin
                    ev.start_x = cur.pos_x;
                    ev.start_y = cur.pos_y;
                    ev.end_x   = clamp_q(longint'($signed(cur.pos_x))
                                         + longint'($signed(cur.dir_x)));
                    ev.end_y   = clamp_q(longint'($signed(cur.pos_y))
                                         + longint'($signed(cur.dir_y)));
                    ev.grey    = cur.grey;
                    cur.pos_x  = ev.end_x;
                    cur.pos_y  = ev.end_y;
                    due_events.insert(due_events.size(), ev);
                    segments++;
                end
                SYM_PUSH: begin
                    if (depth >= STACK_DEPTH) begin
                        ev.kind = EV_OVER;
                        due_events.insert(due_events.size(), ev);
                        overflows++;
                    end else begin
                        saved[ADDR_W'(depth)] = cur;
                        depth++;
                        cur.dir_x = clamp_q(round_q16(longint'($signed(cur.dir_x))
                                                      * longint'(dir_gain)));
                        cur.dir_y = clamp_q(round_q16(longint'($signed(cur.dir_y))
                                                      * longint'(dir_gain)));
                        g = round_q16(longint'(cur.grey) * longint'(grey_gain));
                        if (g > longint'(GREY_ONE)) g = longint'(GREY_ONE);
                        cur.grey = g[GREY_W-1:0];
                    end
                end
                SYM_POP: begin
                    if (depth == 0) begin
                        ev.kind = EV_UNDER;
                        due_events.insert(due_events.size(), ev);
                        underflows++;
                    end else begin
                        depth--;
                        cur = saved[ADDR_W'(depth)];
                    end
                end
                SYM_PLUS:  turn(longint'(sin_q));
                SYM_MINUS: turn(-longint'(sin_q));
                default: ;
            endcase
        endfunction

        function void check_field(string name, longint want, longint seen);
            if (want != seen) begin
                $error("%s: expected %0d, got %0d", name, want, seen);
                errors++;
            end
        endfunction

        // Compare a result item with the oldest prediction
        function void check_event(t_evt got);
            t_evt want;
            if (due_events.size() == 0) begin
                $error("result item with no prediction pending: kind %0d", int'(got.kind));
                errors++;
                return;
            end
            want = due_events.pop_front();
            check_field("event_kind", longint'(want.kind), longint'(got.kind));
            check_field("seg_start_x", longint'($signed(want.start_x)),
                        longint'($signed(got.start_x)));
            check_field("seg_start_y", longint'($signed(want.start_y)),
                        longint'($signed(got.start_y)));
            check_field("seg_end_x", longint'($signed(want.end_x)),
                        longint'($signed(got.end_x)));
            check_field("seg_end_y", longint'($signed(want.end_y)),
                        longint'($signed(got.end_y)));
            check_field("seg_grey", longint'(want.grey), longint'(got.grey));
        endfunction
    endclass

    localparam int IDLE_LIMIT  = 2000;
    localparam int SETTLE      = 12;
    localparam int PHASE_ITEMS = 220;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    lti_sym_if sym_bus();
    lti_evt_if evt_bus();

    turtle_scoreboard model;
    bit               sym_gaps_on;
    bit               evt_stalls_on;
    int unsigned      items_sent;
    int unsigned      settings_used;
    int unsigned      idle_cycles;

    lsystem_turtle_interpreter_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sym      (sym_bus),
        .o_evt      (evt_bus)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side: stall at random while stalls are enabled
    initial begin
        evt_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            evt_bus.ready <= !evt_stalls_on || ($urandom_range(99) >= 17);
        end
    end

    // Check every accepted result item
    always @(posedge i_clk) begin
        t_evt got;
        if (i_rst_n && evt_bus.valid && evt_bus.ready) begin
            got.kind    = t_evt_kind'(evt_bus.event_kind);
            got.start_x = evt_bus.seg_start_x;
            got.start_y = evt_bus.seg_start_y;
            got.end_x   = evt_bus.seg_end_x;
            got.end_y   = evt_bus.seg_end_y;
            got.grey    = evt_bus.seg_grey;
            model.check_event(got);
        end
    end

    // End the run when nothing moves for too long
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((sym_bus.valid && sym_bus.ready) || (evt_bus.valid && evt_bus.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // Offer one symbol, with random gaps, until it is taken
    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic restart);
        while (sym_gaps_on && $urandom_range(99) < 17) begin
            sym_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        sym_bus.valid     <= 1'b1;
        sym_bus.symbol    <= sym;
        sym_bus.start_new <= restart;
        do @(posedge i_clk); while (!sym_bus.ready);
        model.note_symbol(sym, restart);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Hold the sender until every predicted result has come out
    task automatic wait_drain();
        sym_bus.valid <= 1'b0;
        @(negedge i_clk);
        while (model.due_events.size() != 0) @(negedge i_clk);
    endtask

    // Write all four registers while the block is idle
    task automatic apply_settings(input logic [CFG_W-1:0] cos_v, input logic [CFG_W-1:0] sin_v,
                                  input logic [CFG_W-1:0] dsc_v, input logic [CFG_W-1:0] csc_v);
        logic [CFG_W-1:0] vals[4];
        vals = '{cos_v, sin_v, dsc_v, csc_v};
        wait_drain();
        repeat (SETTLE) @(negedge i_clk);
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= vals[CFG_IDX_W'(i)];
            model.set_reg(CFG_IDX_W'(i), vals[CFG_IDX_W'(i)]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Balanced plant string: draw, turn, nested branches and stray bytes
    task automatic send_plant(input int unsigned len);
        int unsigned nest;
        int unsigned r;
        logic        restart;
        nest    = 0;
        restart = 1'($urandom_range(1));
        for (int unsigned i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (r < 40) begin
                send_symbol(SYM_FWD, restart);
            end else if (r < 55) begin
                send_symbol(SYM_PLUS, restart);
            end else if (r < 70) begin
                send_symbol(SYM_MINUS, restart);
            end else if (r < 82 && nest < 8) begin
                send_symbol(SYM_PUSH, restart);
                nest++;
            end else if (r < 94 && nest > 0) begin
                send_symbol(SYM_POP, restart);
                nest--;
            end else begin
                send_symbol(SYM_W'($urandom_range(255)), restart);
            end
            restart = 1'b0;
        end
        while (nest > 0) begin
            send_symbol(SYM_POP, 1'b0);
            nest--;
        end
    endtask

    // Push near or past the stack limit, then pop near or past empty
    task automatic send_dive();
        int unsigned pushes;
        int unsigned pops;
        pushes = $urandom_range(62, 68);
        pops   = $urandom_range(60, 70);
        send_symbol(SYM_PUSH, 1'b1);
        for (int unsigned i = 1; i < pushes; i++) begin
            if ($urandom_range(99) < 15) send_symbol(SYM_FWD, 1'b0);
            send_symbol(SYM_PUSH, 1'b0);
        end
        for (int unsigned i = 0; i < pops; i++) begin
            send_symbol(SYM_POP, 1'b0);
            if ($urandom_range(99) < 15) send_symbol(SYM_FWD, 1'b0);
        end
    endtask

    // Arbitrary bytes and restart flags
    task automatic send_noise(input int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            send_symbol(SYM_W'($urandom_range(255)), ($urandom_range(99) < 25));
        end
    endtask

    // Unbalanced mix of the five acted-on symbols
    task automatic send_broken(input int unsigned len);
        logic [SYM_W-1:0] pick[5];
        pick = '{SYM_FWD, SYM_PUSH, SYM_POP, SYM_PLUS, SYM_MINUS};
        for (int unsigned i = 0; i < len; i++) begin
            send_symbol(pick[3'($urandom_range(4))], ($urandom_range(99) < 5));
        end
    endtask

    // Random part of one phase
    task automatic run_phase(input bit dive_first);
        int unsigned goal;
        int unsigned r;
        goal = items_sent + PHASE_ITEMS;
        if (dive_first) send_dive();
        while (items_sent < goal) begin
            r = $urandom_range(99);
            if (r < 3) begin
                wait_drain();
            end else if (r < 58) begin
                send_plant($urandom_range(5, 40));
            end else if (r < 62) begin
                send_dive();
            end else if (r < 80) begin
                send_noise($urandom_range(1, 10));
            end else begin
                send_broken($urandom_range(3, 15));
            end
        end
    endtask

    initial begin
        model             = new();
        items_sent        = 0;
        settings_used     = 1;
        sym_gaps_on       = 1'b1;
        evt_stalls_on     = 1'b1;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        sym_bus.valid     = 1'b0;
        sym_bus.symbol    = '0;
        sym_bus.start_new = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: every operation, restarts, ignored bytes, underflow
        send_symbol(SYM_FWD, 1'b0);
        send_symbol(SYM_FWD, 1'b0);
        send_symbol(SYM_PUSH, 1'b0);
        send_symbol(SYM_FWD, 1'b0);
        send_symbol(SYM_POP, 1'b0);
        send_symbol(SYM_POP, 1'b0);
        send_symbol(SYM_PLUS, 1'b0);
        send_symbol(SYM_MINUS, 1'b0);
        send_symbol(SYM_FWD, 1'b0);
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'h66, 1'b0);
        send_symbol(SYM_FWD, 1'b1);
        send_symbol(SYM_PUSH, 1'b0);
        send_symbol(SYM_POP, 1'b1);
        send_symbol(SYM_PUSH, 1'b1);
        send_symbol(SYM_PUSH, 1'b0);
        send_symbol(SYM_FWD, 1'b0);
        send_symbol(SYM_POP, 1'b0);
        send_symbol(SYM_POP, 1'b0);
        send_symbol(SYM_POP, 1'b0);
        send_symbol(8'hAA, 1'b1);
        send_symbol(SYM_FWD, 1'b0);

        // Reset settings, with a stack dive first
        run_phase(1'b1);

        // Quarter turn, shrinking branches
        apply_settings(18'h00000, 18'h10000, 18'h0B333, 18'h0CCCD);
        run_phase(1'b0);

        // Shallow angle with no gaps or stalls on either side
        sym_gaps_on   = 1'b0;
        evt_stalls_on = 1'b0;
        apply_settings(18'h0E804, 18'h06C31, 18'h0999A, 18'h0E666);
        run_phase(1'b0);
        sym_gaps_on   = 1'b1;
        evt_stalls_on = 1'b1;

        // Out-of-range extremes: growth and saturation
        apply_settings(18'h20000, 18'h1FFFF, 18'h3FFFF, 18'h3FFFF);
        run_phase(1'b1);

        // Lowest in-range values
        apply_settings(18'h30000, 18'h30000, 18'h00000, 18'h00000);
        run_phase(1'b0);

        // Highest in-range values
        apply_settings(18'h10000, 18'h10000, 18'h10000, 18'h10000);
        run_phase(1'b0);

        // Fully random register values
        apply_settings(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
        run_phase(1'b0);

        wait_drain();
        repeat (SETTLE) @(negedge i_clk);
        if (model.due_events.size() != 0) begin
            $error("%0d predicted results never came out", model.due_events.size());
            model.errors++;
        end

        $display("Run covered %0d symbols over %0d register settings.",
                 items_sent, settings_used);
        $display("Checked %0d segments, %0d stack underflows and %0d stack overflows.",
                 model.segments, model.underflows, model.overflows);
        if (model.errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
